[design/tsv_pkg.sv]
// Shared types and constants for the triple sensor voter.
`timescale 1ns / 1ps

package tsv_pkg;

  // Fixed field widths
  localparam int unsigned ThreshWidth = 16;
  localparam int unsigned MaskWidth   = 3;
  localparam int unsigned ConfWidth   = 2;

  // Agreement threshold after reset: 2.0 in Q8.8
  localparam logic [ThreshWidth-1:0] ThreshReset = 16'd512;

  // Health mask codes, bit i set while sensor i is healthy
  localparam logic [MaskWidth-1:0] MaskAll  = 3'b111;
  localparam logic [MaskWidth-1:0] MaskAB   = 3'b011;
  localparam logic [MaskWidth-1:0] MaskBC   = 3'b110;
  localparam logic [MaskWidth-1:0] MaskAC   = 3'b101;
  localparam logic [MaskWidth-1:0] MaskNone = 3'b000;

  // Confidence of a voted result
  typedef enum logic [ConfWidth-1:0] {
    CONF_ALL  = 2'd0,
    CONF_TWO  = 2'd1,
    CONF_FAIL = 2'd2
  } conf_e;

endpackage

[design/tsv_health.sv]
// Health mask update: pairwise agreement checks and fault latching.
`timescale 1ns / 1ps

module tsv_health #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_a_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_b_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_c_i,
  input  logic [tsv_pkg::ThreshWidth-1:0]       thresh_i,
  input  logic [tsv_pkg::MaskWidth-1:0]         mask_i,
  output logic [tsv_pkg::MaskWidth-1:0]         mask_o
);

  localparam int unsigned DiffW = SAMPLE_WIDTH + 1;
  localparam int unsigned CmpW  = (DiffW > tsv_pkg::ThreshWidth) ? DiffW : tsv_pkg::ThreshWidth;

  logic signed [DiffW-1:0] diff_ab, diff_bc, diff_ac;
  logic [DiffW-1:0]        abs_ab, abs_bc, abs_ac;
  logic [CmpW-1:0]         thresh_ext;
  logic                    agree_ab, agree_bc, agree_ac;

  // Form differences at full precision so nothing wraps
  assign diff_ab = DiffW'(sample_a_i) - DiffW'(sample_b_i);
  assign diff_bc = DiffW'(sample_b_i) - DiffW'(sample_c_i);
  assign diff_ac = DiffW'(sample_a_i) - DiffW'(sample_c_i);

  assign abs_ab = diff_ab[DiffW-1] ? DiffW'(-diff_ab) : DiffW'(diff_ab);
  assign abs_bc = diff_bc[DiffW-1] ? DiffW'(-diff_bc) : DiffW'(diff_bc);
  assign abs_ac = diff_ac[DiffW-1] ? DiffW'(-diff_ac) : DiffW'(diff_ac);

  // Compare magnitudes against the threshold
  assign thresh_ext = CmpW'(thresh_i);
  assign agree_ab   = CmpW'(abs_ab) <= thresh_ext;
  assign agree_bc   = CmpW'(abs_bc) <= thresh_ext;
  assign agree_ac   = CmpW'(abs_ac) <= thresh_ext;

  // Drop disagreeing sensors; one or none healthy holds the mask
  always_comb begin
    mask_o = mask_i;
    case (mask_i)
      tsv_pkg::MaskAll: begin
        if (agree_ab && agree_bc && agree_ac) begin
          mask_o = tsv_pkg::MaskAll;
        end else if (agree_ab && !agree_bc && !agree_ac) begin
          mask_o = tsv_pkg::MaskAB;
        end else if (!agree_ab && agree_bc && !agree_ac) begin
          mask_o = tsv_pkg::MaskBC;
        end else if (!agree_ab && !agree_bc && agree_ac) begin
          mask_o = tsv_pkg::MaskAC;
        end else begin
          mask_o = tsv_pkg::MaskNone;
        end
      end
      tsv_pkg::MaskBC: begin
        if (!agree_bc) mask_o = tsv_pkg::MaskNone;
      end
      tsv_pkg::MaskAC: begin
        if (!agree_ac) mask_o = tsv_pkg::MaskNone;
      end
      tsv_pkg::MaskAB: begin
        if (!agree_ab) mask_o = tsv_pkg::MaskNone;
      end
      default: begin
        mask_o = mask_i;
      end
    endcase
  end

endmodule

[design/tsv_mean.sv]
// Mean of the healthy samples, truncated toward zero, and confidence code.
`timescale 1ns / 1ps

module tsv_mean #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic signed [SAMPLE_WIDTH-1:0]  sample_a_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample_b_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  sample_c_i,
  input  logic [tsv_pkg::MaskWidth-1:0]   mask_i,
  output logic signed [SAMPLE_WIDTH-1:0]  voted_o,
  output tsv_pkg::conf_e                  conf_o
);

  localparam int unsigned SumW       = SAMPLE_WIDTH + 2;
  localparam int unsigned MagW       = SAMPLE_WIDTH + 1;
  localparam int unsigned RecipShift = MagW + 1;
  localparam int unsigned ProdW      = 2 * MagW;
  // ceil(2^(MagW+1) / 3): exact quotient by 3 for any MagW-bit dividend
  localparam logic [MagW-1:0] Recip  =
    MagW'(((64'd1 << RecipShift) + 64'd2) / 64'd3);

  logic signed [SumW-1:0] term_a, term_b, term_c, sum;
  logic [SumW-1:0]        sum_abs;
  logic [MagW-1:0]        mag;
  logic [ProdW-1:0]       prod;
  logic [SAMPLE_WIDTH-1:0] quot;
  logic [1:0]             count;

  // Sum only the healthy samples
  assign term_a = mask_i[0] ? SumW'(sample_a_i) : '0;
  assign term_b = mask_i[1] ? SumW'(sample_b_i) : '0;
  assign term_c = mask_i[2] ? SumW'(sample_c_i) : '0;
  assign sum    = term_a + term_b + term_c;
  assign count  = 2'(mask_i[0]) + 2'(mask_i[1]) + 2'(mask_i[2]);

  // Divide the magnitude so the quotient truncates toward zero
  assign sum_abs = sum[SumW-1] ? SumW'(-sum) : SumW'(sum);
  assign mag     = sum_abs[MagW-1:0];
  assign prod    = ProdW'(mag) * ProdW'(Recip);

  always_comb begin
    if (count == 2'd3) begin
      quot = prod[ProdW-1:RecipShift];
    end else begin
      quot = mag[MagW-1:1];
    end
  end

  // Restore the sign; zero and failure on one or no healthy sensor
  always_comb begin
    case (count)
      2'd3: begin
        conf_o  = tsv_pkg::CONF_ALL;
        voted_o = sum[SumW-1] ? SAMPLE_WIDTH'(-quot) : quot;
      end
      2'd2: begin
        conf_o  = tsv_pkg::CONF_TWO;
        voted_o = sum[SumW-1] ? SAMPLE_WIDTH'(-quot) : quot;
      end
      default: begin
        conf_o  = tsv_pkg::CONF_FAIL;
        voted_o = '0;
      end
    endcase
  end

endmodule

[design/triple_sensor_voter.sv]
// Top level of the triple sensor voter: input stage, voting logic, result stage.
// An accepted request waits in the input register; the vote and mean sit between
// it and the result register, which drives the outputs. Throughput: one request
// per cycle while out_stall_i is low; the health mask updates with each vote.
// Reset: both stages empty, health mask all healthy, threshold 512 (2.0 Q8.8).
`timescale 1ns / 1ps

module triple_sensor_voter #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration
  input  logic                              cfg_we_i,
  input  logic [tsv_pkg::ThreshWidth-1:0]   cfg_wdata_i,
  // Request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_a_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_b_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_c_i,
  // Result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]    voted_value_o,
  output logic [tsv_pkg::ConfWidth-1:0]     confidence_o,
  output logic [tsv_pkg::MaskWidth-1:0]     healthy_mask_o
);

  logic [tsv_pkg::ThreshWidth-1:0] thresh_q;
  logic [tsv_pkg::MaskWidth-1:0]   health_q, health_d;
  logic                            in_valid_q;
  logic signed [SAMPLE_WIDTH-1:0]  sample_a_q, sample_b_q, sample_c_q;
  logic                            out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0]  voted_q, voted_d;
  tsv_pkg::conf_e                  conf_q, conf_d;
  logic [tsv_pkg::MaskWidth-1:0]   mask_out_q;
  logic                            out_free, in_accept, vote_load;

  // Handshake control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign vote_load  = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Hold the agreement threshold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= tsv_pkg::ThreshReset;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  // Input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (vote_load) begin
      in_valid_q <= 1'b0;
    end
  end

  // Capture the request samples
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_a_q <= sample_a_i;
      sample_b_q <= sample_b_i;
      sample_c_q <= sample_c_i;
    end
  end

  tsv_health #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_health (
    .sample_a_i (sample_a_q),
    .sample_b_i (sample_b_q),
    .sample_c_i (sample_c_q),
    .thresh_i   (thresh_q),
    .mask_i     (health_q),
    .mask_o     (health_d)
  );

  tsv_mean #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_mean (
    .sample_a_i (sample_a_q),
    .sample_b_i (sample_b_q),
    .sample_c_i (sample_c_q),
    .mask_i     (health_d),
    .voted_o    (voted_d),
    .conf_o     (conf_d)
  );

  // Advance the health mask as each request is voted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      health_q <= tsv_pkg::MaskAll;
    end else if (vote_load) begin
      health_q <= health_d;
    end
  end

  // Result stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (vote_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Capture the result
  always_ff @(posedge clk_i) begin
    if (vote_load) begin
      voted_q    <= voted_d;
      conf_q     <= conf_d;
      mask_out_q <= health_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign voted_value_o  = voted_q;
  assign confidence_o   = conf_q;
  assign healthy_mask_o = mask_out_q;

endmodule

[sim/triple_sensor_voter_tb.sv]
// Self-checking testbench for the triple sensor voter.
`timescale 1ns / 1ps

module triple_sensor_voter_tb;

  localparam int SW = 16;
  localparam int unsigned ThreshMax = 65535;
  // Drain margin for the input and result registers
  localparam int DrainCycles = 4;

  typedef struct packed {
    logic signed [SW-1:0]          value;
    tsv_pkg::conf_e                conf;
    logic [tsv_pkg::MaskWidth-1:0] mask;
  } vote_t;

  // Tracks the health mask and threshold, predicts each vote, checks results
  class vote_scoreboard;
    logic [tsv_pkg::ThreshWidth-1:0] threshold;
    logic [tsv_pkg::MaskWidth-1:0]   health;
    vote_t                           expected_votes[$];
    int                              errors;

    function new();
      threshold = tsv_pkg::ThreshReset;
      health    = tsv_pkg::MaskAll;
      errors    = 0;
    endfunction

    function void set_threshold(logic [tsv_pkg::ThreshWidth-1:0] t);
      threshold = t;
    endfunction

    function bit within_threshold(int x, int y);
      int d;
      d = x - y;
      if (d < 0) d = -d;
      return d <= int'(threshold);
    endfunction

    // Update the latched mask, then average the surviving samples
    function void note_request(logic signed [SW-1:0] a, logic signed [SW-1:0] b,
                               logic signed [SW-1:0] c);
      int    s[3];
      int    sum;
      int    cnt;
      bit    ab, bc, ac;
      vote_t want;
      s[0] = a;
      s[1] = b;
      s[2] = c;
      ab = within_threshold(s[0], s[1]);
      bc = within_threshold(s[1], s[2]);
      ac = within_threshold(s[0], s[2]);
      case (health)
        tsv_pkg::MaskAll: begin
          if (ab && bc && ac) health = tsv_pkg::MaskAll;
          else if (ab && !bc && !ac) health = tsv_pkg::MaskAB;
          else if (!ab && bc && !ac) health = tsv_pkg::MaskBC;
          else if (!ab && !bc && ac) health = tsv_pkg::MaskAC;
          else health = tsv_pkg::MaskNone;
        end
        tsv_pkg::MaskBC: if (!bc) health = tsv_pkg::MaskNone;
        tsv_pkg::MaskAC: if (!ac) health = tsv_pkg::MaskNone;
        tsv_pkg::MaskAB: if (!ab) health = tsv_pkg::MaskNone;
        default: ;
      endcase
      sum = 0;
      cnt = 0;
      for (int i = 0; i < 3; i++) begin
        if (health[i]) begin
          sum += s[i];
          cnt++;
        end
      end
      want.mask = health;
      if (cnt == 3) begin
        want.value = SW'(sum / 3);
        want.conf  = tsv_pkg::CONF_ALL;
      end else if (cnt == 2) begin
        want.value = SW'(sum / 2);
        want.conf  = tsv_pkg::CONF_TWO;
      end else begin
        want.value = '0;
        want.conf  = tsv_pkg::CONF_FAIL;
      end
      expected_votes.push_back(want);
    endfunction

    function void check_result(logic signed [SW-1:0] v, logic [tsv_pkg::ConfWidth-1:0] c,
                               logic [tsv_pkg::MaskWidth-1:0] m);
      vote_t want;
      if (expected_votes.size() == 0) begin
        $error("unexpected result: voted_value %0d confidence %0d healthy_mask %0d",
               v, c, m);
        errors++;
        return;
      end
      want = expected_votes.pop_front();
      if (v !== want.value) begin
        $error("voted_value: expected %0d, got %0d", want.value, v);
        errors++;
      end
      if (c !== want.conf) begin
        $error("confidence: expected %0d, got %0d", want.conf, c);
        errors++;
      end
      if (m !== want.mask) begin
        $error("healthy_mask: expected %0d, got %0d", want.mask, m);
        errors++;
      end
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [tsv_pkg::ThreshWidth-1:0] cfg_wdata_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic signed [SW-1:0]            sample_a_i = '0;
  logic signed [SW-1:0]            sample_b_i = '0;
  logic signed [SW-1:0]            sample_c_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic signed [SW-1:0]            voted_value_o;
  logic [tsv_pkg::ConfWidth-1:0]   confidence_o;
  logic [tsv_pkg::MaskWidth-1:0]   healthy_mask_o;

  vote_scoreboard sb;
  bit             src_burst = 1'b0;
  bit             snk_burst = 1'b0;

  triple_sensor_voter #(
    .SAMPLE_WIDTH(SW)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_a_i    (sample_a_i),
    .sample_b_i    (sample_b_i),
    .sample_c_i    (sample_c_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .voted_value_o (voted_value_o),
    .confidence_o  (confidence_o),
    .healthy_mask_o(healthy_mask_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Record accepted requests and check accepted results
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_request(sample_a_i, sample_b_i, sample_c_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(voted_value_o, confidence_o, healthy_mask_o);
  end

  // Stall the result side at random, with occasional stretches of no stall
  initial begin
    int hold;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) snk_burst = !snk_burst;
      hold = snk_burst ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic int rand_in(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Offset within [0, t], biased toward both ends
  function automatic int pick_offset(int t);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return t;
      default: return rand_in(0, t);
    endcase
  endfunction

  task automatic send_triple(input int a, input int b, input int c);
    int gap;
    if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_a_i <= SW'(a);
    sample_b_i <= SW'(b);
    sample_c_i <= SW'(c);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid, let the last request reach the scoreboard, drain, then write
  task automatic write_threshold(input int t);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_votes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= tsv_pkg::ThreshWidth'(t);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_threshold(tsv_pkg::ThreshWidth'(t));
  endtask

  // Three samples spread no wider than t
  task automatic send_agreeing(input int t);
    int base;
    base = rand_in(-32768, 32767 - t);
    send_triple(base + pick_offset(t), base + pick_offset(t), base + pick_offset(t));
  endtask

  // Place the pair values on the two sensors of the mask, odd value on the third
  task automatic send_with_pair(input logic [tsv_pkg::MaskWidth-1:0] pair, input int p,
                                input int q, input int odd);
    int x, y;
    if ($urandom_range(0, 1)) begin
      x = q;
      y = p;
    end else begin
      x = p;
      y = q;
    end
    case (pair)
      tsv_pkg::MaskAB: send_triple(x, y, odd);
      tsv_pkg::MaskBC: send_triple(odd, x, y);
      default:         send_triple(x, odd, y);
    endcase
  endtask

  task automatic send_pair_agreeing(input logic [tsv_pkg::MaskWidth-1:0] pair, input int t);
    int base;
    base = rand_in(-32768, 32767 - t);
    send_with_pair(pair, base + pick_offset(t), base + pick_offset(t),
                   rand_in(-32768, 32767));
  endtask

  initial begin
    int t;
    int p, d, odd, r, noise_phases;
    int v[3];
    logic [tsv_pkg::MaskWidth-1:0] pair;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset threshold: extremes, boundary agreement, truncation of negative means
    send_triple(0, 0, 0);
    send_triple(-32768, -32768, -32768);
    send_triple(32767, 32767, 32767);
    send_triple(100, 612, 356);
    send_triple(-1, -1, -2);
    send_triple(-2, -2, -1);
    send_triple(32767, 32767, 32255);
    send_triple(-32768, -32256, -32512);

    // Widest threshold: every pair agrees, full-scale spreads
    write_threshold(ThreshMax);
    send_triple(32767, -32768, 0);
    send_triple(-32768, 32767, 32767);
    send_triple(-32768, -32768, 32767);
    send_triple(21845, -21846, 0);
    send_triple(-5, 2, 1);

    // Zero threshold: only identical samples agree
    write_threshold(0);
    send_triple(7, 7, 7);
    send_triple(-300, -300, -300);
    send_triple(-32768, -32768, -32768);

    // Random agreeing triples over a range of thresholds, all sensors healthy
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: t = 1;
        1: t = ThreshMax;
        2: t = 0;
        default: t = $urandom_range(0, 1) ? rand_in(2, 4000) : rand_in(4001, 65534);
      endcase
      write_threshold(t);
      repeat (150) send_agreeing(t);
    end

    t = rand_in(1, 2000);
    write_threshold(t);
    if ($urandom_range(0, 3) != 0) begin
      // Drop one odd sensor, keep the pair alive, then break the pair
      case ($urandom_range(0, 2))
        0: pair = tsv_pkg::MaskAB;
        1: pair = tsv_pkg::MaskBC;
        default: pair = tsv_pkg::MaskAC;
      endcase
      p = rand_in(-10000, 10000);
      d = rand_in(0, t);
      r = $urandom_range(0, 1) ? 0 : rand_in(0, 5000);
      if ($urandom_range(0, 1)) odd = p + d + t + 1 + r;
      else odd = p - t - 1 - r;
      send_with_pair(pair, p, p + d, odd);
      repeat (130) send_pair_agreeing(pair, t);
      write_threshold(ThreshMax);
      repeat (130) send_pair_agreeing(pair, ThreshMax);
      t = $urandom_range(0, 1) ? 0 : rand_in(1, 3000);
      write_threshold(t);
      repeat (130) send_pair_agreeing(pair, t);
      p = rand_in(-32768, 32766 - t);
      r = $urandom_range(0, 1) ? 0 : rand_in(0, 32766 - t - p);
      send_with_pair(pair, p, p + t + 1 + r, rand_in(-32768, 32767));
      noise_phases = 3;
    end else begin
      // Drop all three at once: two chained pairs agree, or no pair agrees
      p = rand_in(-10000, 10000);
      if ($urandom_range(0, 1)) begin
        v[0] = p;
        v[1] = p + t;
        v[2] = p + 2 * t;
      end else begin
        v[0] = p;
        v[1] = p + t + 1;
        v[2] = p + 2 * t + 2 + rand_in(0, 5000);
      end
      case ($urandom_range(0, 5))
        0: send_triple(v[0], v[1], v[2]);
        1: send_triple(v[0], v[2], v[1]);
        2: send_triple(v[1], v[0], v[2]);
        3: send_triple(v[1], v[2], v[0]);
        4: send_triple(v[2], v[0], v[1]);
        default: send_triple(v[2], v[1], v[0]);
      endcase
      noise_phases = 7;
    end

    // Mask is latched now: arbitrary samples under arbitrary thresholds
    for (int ph = 0; ph < noise_phases; ph++) begin
      write_threshold(ph == 0 ? 0 : int'($urandom_range(0, ThreshMax)));
      repeat (100)
        send_triple(rand_in(-32768, 32767), rand_in(-32768, 32767), rand_in(-32768, 32767));
    end

    // Drain and report
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_votes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles * 2) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("triple_sensor_voter verification clean");
    end else begin
      $display("triple_sensor_voter verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8000000;
    $display("triple_sensor_voter verification failed");
    $finish;
  end

endmodule
